[rtl/core/rnp_pkg.sv]
// shared types and constants of the rtp h.264 nal packetizer
// no dependencies; used by every module of the block
package rnp_pkg;

    localparam int SIZE_BITS_DEFAULT = 24;
    localparam int CMD_FIFO_DEPTH    = 4;   // power of two

    // configuration register indexes
    localparam logic [2:0] CFG_PAYLOAD_LIMIT = 3'd0;
    localparam logic [2:0] CFG_PREFIX_ON     = 3'd1;
    localparam logic [2:0] CFG_CHANNEL_ID    = 3'd2;
    localparam logic [2:0] CFG_PAYLOAD_TYPE  = 3'd3;
    localparam logic [2:0] CFG_SSRC          = 3'd4;

    localparam logic [15:0] LIMIT_RESET   = 16'(1280 - 18);
    localparam logic        PREFIX_RESET  = 1'b1;
    localparam logic [7:0]  CHANNEL_RESET = 8'd1;
    localparam logic [7:0]  PT_RESET      = 8'h60;
    localparam logic [31:0] SSRC_RESET    = 32'd0;

    localparam logic [7:0] PREFIX_DOLLAR = 8'h24;
    localparam logic [7:0] RTP_VERSION   = 8'h80;
    localparam logic [7:0] FU_A_TYPE     = 8'h1C;
    localparam logic [7:0] NRI_MASK      = 8'hE0;
    localparam logic [7:0] TYPE_MASK     = 8'h1F;
    localparam logic [7:0] FU_START_BIT  = 8'h80;
    localparam logic [7:0] FU_END_BIT    = 8'h40;
    localparam logic [15:0] RTP_HDR_LEN  = 16'd12;
    localparam logic [15:0] FU_HDR_LEN   = 16'd2;

    typedef struct packed {
        logic        prefix_on;
        logic [7:0]  channel_id;
        logic [7:0]  payload_type;
        logic [31:0] ssrc;
    } cfg_t;

    // one classified nal byte, handed from front to back
    typedef struct packed {
        logic [7:0]  data;
        logic        start;      // open a new packet before the byte
        logic        fu;
        logic        first;
        logic        last;
        logic        pkt_end;
        logic [15:0] seq;
        logic [31:0] ts;
        logic [15:0] len;
        logic [7:0]  hdr;
    } cmd_t;

endpackage

[rtl/core/rtp_h264_nal_packetizer_top.sv]
// top level of the rtp h.264 nal packetizer: config registers, front, queue, back
// depends on rnp_pkg, rnp_front, rnp_fifo, rnp_back
//
// NAL bytes enter on s_* at up to one byte per cycle, each carrying the NAL size and
// timestamp; RTP packets leave on m_* as bytes, tlast on the last byte of a packet and
// tuser on the last byte caused by an input byte. A small NAL becomes one packet, a NAL above
// payload_limit is cut into FU-A fragments. The front classifies each byte combinationally;
// the back emits one output byte per cycle unless the output stalls, so a byte that opens a
// packet becomes 13 to 19 output bytes (prefix, 12 header bytes, FU bytes, data), every other
// byte one, a fragmented NAL's header byte none. A four-entry command queue between them
// absorbs the header bursts; input stalls only while it is full. No clearing pass after reset.
module rtp_h264_nal_packetizer_top #(
    parameter int SIZE_BITS = rnp_pkg::SIZE_BITS_DEFAULT,
    parameter int FIFO_DEPTH = rnp_pkg::CMD_FIFO_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,     // data_byte[7:0], frame_size[31:8], timestamp[63:32]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,     // out_byte[7:0]
    output logic        m_tlast,
    output logic        m_tuser,     // run_last
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    logic [15:0]   limit_reg, limit_next;
    rnp_pkg::cfg_t cfg_reg, cfg_next;

    logic          accept, push, fifo_full, head_valid, pop;
    rnp_pkg::cmd_t push_cmd, head_cmd;
    logic [$clog2(FIFO_DEPTH):0] fifo_count;

    assign cfg_ready = 1'b1;
    assign s_tready  = !fifo_full;
    assign accept    = s_tvalid && s_tready;

    always_comb
    begin
        limit_next = limit_reg;
        cfg_next   = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                rnp_pkg::CFG_PAYLOAD_LIMIT: limit_next = cfg_data[15:0];
                rnp_pkg::CFG_PREFIX_ON:     cfg_next.prefix_on = cfg_data[0];
                rnp_pkg::CFG_CHANNEL_ID:    cfg_next.channel_id = cfg_data[7:0];
                rnp_pkg::CFG_PAYLOAD_TYPE:  cfg_next.payload_type = cfg_data[7:0];
                rnp_pkg::CFG_SSRC:          cfg_next.ssrc = cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg            <= rnp_pkg::LIMIT_RESET;
            cfg_reg.prefix_on    <= rnp_pkg::PREFIX_RESET;
            cfg_reg.channel_id   <= rnp_pkg::CHANNEL_RESET;
            cfg_reg.payload_type <= rnp_pkg::PT_RESET;
            cfg_reg.ssrc         <= rnp_pkg::SSRC_RESET;
        end
        else
        begin
            limit_reg <= limit_next;
            cfg_reg   <= cfg_next;
        end
    end

    rnp_front #(
        .SIZE_BITS(SIZE_BITS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .data_byte    (s_tdata[7:0]),
        .frame_size   (s_tdata[31:8]),
        .timestamp    (s_tdata[63:32]),
        .payload_limit(limit_reg),
        .push         (push),
        .cmd          (push_cmd)
    );

    rnp_fifo #(
        .DEPTH(FIFO_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_cmd  (push_cmd),
        .pop       (pop),
        .full      (fifo_full),
        .head_valid(head_valid),
        .head_cmd  (head_cmd),
        .count     (fifo_count)
    );

    rnp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .head_valid(head_valid),
        .head_cmd  (head_cmd),
        .pop       (pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_byte  (m_tdata),
        .packet_end(m_tlast),
        .run_last  (m_tuser)
    );

    // a packet always ends on a data byte, which is the last byte of its transaction run
    a_end_on_data: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast |-> m_tuser)
        else $error("packet end away from data byte");

    // front never pushes into a full queue
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !fifo_full)
        else $error("command queue overflow");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        fifo_count <= ($clog2(FIFO_DEPTH)+1)'(FIFO_DEPTH))
        else $error("command queue count out of range");

    // the back only pops what is there
    a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head_valid)
        else $error("pop from empty queue");

endmodule

[rtl/core/rnp_front.sv]
// front part: takes nal bytes, tracks nal and packet position, classifies each byte
// depends on rnp_pkg
module rnp_front #(
    parameter int SIZE_BITS = rnp_pkg::SIZE_BITS_DEFAULT
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          accept,
    input  logic [7:0]    data_byte,
    input  logic [23:0]   frame_size,
    input  logic [31:0]   timestamp,
    input  logic [15:0]   payload_limit,
    output logic          push,
    output rnp_pkg::cmd_t cmd
);

    logic [15:0]          seq_reg, seq_next;
    logic [SIZE_BITS-1:0] pos_reg, pos_next;
    logic [15:0]          pbl_reg, pbl_next;
    logic [7:0]           hdr_reg, hdr_next;
    logic                 frag_reg, frag_next;

    logic [15:0]          lim;
    logic [SIZE_BITS-1:0] size_w, size, lim_w, remaining;
    logic [SIZE_BITS:0]   pos_inc;
    logic [15:0]          n, pbl_cur, pbl_after;
    logic                 at_start, frag_cur, pkt_start, ended, skip;

    always_comb
    begin
        lim       = (payload_limit == 16'd0) ? 16'd1 : payload_limit;
        size_w    = SIZE_BITS'(frame_size);
        size      = (size_w == '0) ? SIZE_BITS'(1) : size_w;
        lim_w     = SIZE_BITS'(lim);
        at_start  = (pos_reg == '0);
        frag_cur  = at_start ? (size > lim_w) : frag_reg;
        pbl_cur   = at_start ? 16'd0 : pbl_reg;
        remaining = (size > pos_reg) ? (size - pos_reg) : SIZE_BITS'(1);
        n         = (remaining < lim_w) ? remaining[15:0] : lim;
        pkt_start = (pbl_cur == 16'd0);
        pbl_after = (pkt_start ? n : pbl_cur) - 16'd1;
        pos_inc   = {1'b0, pos_reg} + (SIZE_BITS+1)'(1);
        ended     = (pos_inc >= {1'b0, size});
        // header byte of a fragmented nal is consumed
        skip      = at_start && frag_cur;

        push = accept && !skip;

        cmd.data    = data_byte;
        cmd.start   = pkt_start;
        cmd.fu      = frag_cur;
        cmd.first   = (pos_reg == SIZE_BITS'(1));
        cmd.last    = (remaining <= lim_w);
        cmd.pkt_end = ended || (pbl_after == 16'd0);
        cmd.seq     = seq_reg + 16'd1;
        cmd.ts      = timestamp;
        cmd.len     = n + rnp_pkg::RTP_HDR_LEN + (frag_cur ? rnp_pkg::FU_HDR_LEN : 16'd0);
        cmd.hdr     = hdr_reg;

        seq_next  = seq_reg;
        pos_next  = pos_reg;
        pbl_next  = pbl_reg;
        hdr_next  = hdr_reg;
        frag_next = frag_reg;
        if (accept)
        begin
            if (at_start)
                hdr_next = data_byte;
            if (skip)
            begin
                pos_next  = SIZE_BITS'(1);
                frag_next = 1'b1;
                pbl_next  = 16'd0;
            end
            else
            begin
                if (pkt_start)
                    seq_next = seq_reg + 16'd1;
                if (ended)
                begin
                    pos_next  = '0;
                    frag_next = 1'b0;
                    pbl_next  = 16'd0;
                end
                else
                begin
                    pos_next  = pos_inc[SIZE_BITS-1:0];
                    frag_next = frag_cur;
                    pbl_next  = pbl_after;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_reg  <= '0;
            pos_reg  <= '0;
            pbl_reg  <= '0;
            hdr_reg  <= '0;
            frag_reg <= 1'b0;
        end
        else
        begin
            seq_reg  <= seq_next;
            pos_reg  <= pos_next;
            pbl_reg  <= pbl_next;
            hdr_reg  <= hdr_next;
            frag_reg <= frag_next;
        end
    end

endmodule

[rtl/core/rnp_fifo.sv]
// short command queue between front and back
// depends on rnp_pkg
module rnp_fifo #(
    parameter int DEPTH = rnp_pkg::CMD_FIFO_DEPTH
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  rnp_pkg::cmd_t push_cmd,
    input  logic          pop,
    output logic          full,
    output logic          head_valid,
    output rnp_pkg::cmd_t head_cmd,
    output logic [$clog2(DEPTH):0] count
);

    localparam int PTR_W = $clog2(DEPTH);

    rnp_pkg::cmd_t    mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PTR_W:0]   count_reg, count_next;
    logic             do_push, do_pop;

    always_comb
    begin
        full        = (count_reg == (PTR_W+1)'(DEPTH));
        head_valid  = (count_reg != '0);
        head_cmd    = mem_reg[rd_ptr_reg];
        count       = count_reg;
        do_push     = push && !full;
        do_pop      = pop && head_valid;
        wr_ptr_next = do_push ? wr_ptr_reg + PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg + (PTR_W+1)'(do_push) - (PTR_W+1)'(do_pop);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

[rtl/core/rnp_back.sv]
// back part: expands each command into its data byte, led by prefix, rtp header and fu bytes when it opens a packet
// depends on rnp_pkg
module rnp_back (
    input  logic          clk,
    input  logic          rst_n,
    input  rnp_pkg::cfg_t cfg,
    input  logic          head_valid,
    input  rnp_pkg::cmd_t head_cmd,
    output logic          pop,
    output logic          out_valid,
    input  logic          out_ready,
    output logic [7:0]    out_byte,
    output logic          packet_end,
    output logic          run_last
);

    localparam logic [4:0] IDX_DOLLAR = 5'd0;
    localparam logic [4:0] IDX_CHAN   = 5'd1;
    localparam logic [4:0] IDX_LEN_HI = 5'd2;
    localparam logic [4:0] IDX_LEN_LO = 5'd3;
    localparam logic [4:0] IDX_VER    = 5'd4;
    localparam logic [4:0] IDX_PT     = 5'd5;
    localparam logic [4:0] IDX_SEQ_HI = 5'd6;
    localparam logic [4:0] IDX_SEQ_LO = 5'd7;
    localparam logic [4:0] IDX_TS3    = 5'd8;
    localparam logic [4:0] IDX_TS2    = 5'd9;
    localparam logic [4:0] IDX_TS1    = 5'd10;
    localparam logic [4:0] IDX_TS0    = 5'd11;
    localparam logic [4:0] IDX_SSRC3  = 5'd12;
    localparam logic [4:0] IDX_SSRC2  = 5'd13;
    localparam logic [4:0] IDX_SSRC1  = 5'd14;
    localparam logic [4:0] IDX_SSRC0  = 5'd15;
    localparam logic [4:0] IDX_FU_IND = 5'd16;
    localparam logic [4:0] IDX_FU_HDR = 5'd17;
    localparam logic [4:0] IDX_DATA   = 5'd18;

    rnp_pkg::cmd_t cur_reg, cur_next;
    logic          cur_valid_reg, cur_valid_next;
    logic [4:0]    idx_reg, idx_next;
    logic          oval_reg, oval_next;
    logic [7:0]    obyte_reg, obyte_next;
    logic          oend_reg, oend_next;
    logic          olast_reg, olast_next;

    logic          advance, fire, done;
    logic [7:0]    sel_byte, fu_hdr;
    logic [4:0]    start_idx;

    always_comb
    begin
        fu_hdr = cur_reg.hdr & rnp_pkg::TYPE_MASK;
        if (cur_reg.first)
            fu_hdr = fu_hdr | rnp_pkg::FU_START_BIT;
        else if (cur_reg.last)
            fu_hdr = fu_hdr | rnp_pkg::FU_END_BIT;

        case (idx_reg)
            IDX_DOLLAR: sel_byte = rnp_pkg::PREFIX_DOLLAR;
            IDX_CHAN:   sel_byte = cfg.channel_id;
            IDX_LEN_HI: sel_byte = cur_reg.len[15:8];
            IDX_LEN_LO: sel_byte = cur_reg.len[7:0];
            IDX_VER:    sel_byte = rnp_pkg::RTP_VERSION;
            IDX_PT:     sel_byte = cfg.payload_type;
            IDX_SEQ_HI: sel_byte = cur_reg.seq[15:8];
            IDX_SEQ_LO: sel_byte = cur_reg.seq[7:0];
            IDX_TS3:    sel_byte = cur_reg.ts[31:24];
            IDX_TS2:    sel_byte = cur_reg.ts[23:16];
            IDX_TS1:    sel_byte = cur_reg.ts[15:8];
            IDX_TS0:    sel_byte = cur_reg.ts[7:0];
            IDX_SSRC3:  sel_byte = cfg.ssrc[31:24];
            IDX_SSRC2:  sel_byte = cfg.ssrc[23:16];
            IDX_SSRC1:  sel_byte = cfg.ssrc[15:8];
            IDX_SSRC0:  sel_byte = cfg.ssrc[7:0];
            IDX_FU_IND: sel_byte = (cur_reg.hdr & rnp_pkg::NRI_MASK) | rnp_pkg::FU_A_TYPE;
            IDX_FU_HDR: sel_byte = fu_hdr;
            default:    sel_byte = cur_reg.data;
        endcase

        if (!head_cmd.start)
            start_idx = IDX_DATA;
        else if (cfg.prefix_on)
            start_idx = IDX_DOLLAR;
        else
            start_idx = IDX_VER;

        advance = !oval_reg || out_ready;
        fire    = advance && cur_valid_reg;
        done    = fire && (idx_reg == IDX_DATA);
        pop     = head_valid && (!cur_valid_reg || done);

        oval_next  = oval_reg;
        obyte_next = obyte_reg;
        oend_next  = oend_reg;
        olast_next = olast_reg;
        if (advance)
        begin
            oval_next  = cur_valid_reg;
            obyte_next = sel_byte;
            oend_next  = done && cur_reg.pkt_end;
            olast_next = done;
        end

        cur_next       = cur_reg;
        cur_valid_next = cur_valid_reg;
        idx_next       = idx_reg;
        if (pop)
        begin
            cur_next       = head_cmd;
            cur_valid_next = 1'b1;
            idx_next       = start_idx;
        end
        else if (done)
            cur_valid_next = 1'b0;
        else if (fire)
        begin
            if (idx_reg == IDX_SSRC0)
                idx_next = cur_reg.fu ? IDX_FU_IND : IDX_DATA;
            else
                idx_next = idx_reg + 5'd1;
        end

        out_valid  = oval_reg;
        out_byte   = obyte_reg;
        packet_end = oend_reg;
        run_last   = olast_reg;
    end

    always_ff @(posedge clk)
    begin
        cur_reg   <= cur_next;
        obyte_reg <= obyte_next;
        oend_reg  <= oend_next;
        olast_reg <= olast_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            idx_reg       <= IDX_DATA;
            oval_reg      <= 1'b0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            idx_reg       <= idx_next;
            oval_reg      <= oval_next;
        end
    end

endmodule

[verif/rtp_h264_nal_packetizer_top_tb.sv]
// testbench for rtp_h264_nal_packetizer_top: nal bytes in, rtp packet bytes out
// depends on rnp_pkg and the rtl of the packetizer; a built-in predictor checks every output byte
module rtp_h264_nal_packetizer_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [7:0] DOLLAR    = 8'h24;
    localparam logic [7:0] RTP_V2    = 8'h80;
    localparam logic [7:0] FU_A      = 8'h1C;
    localparam logic [7:0] NRI_BITS  = 8'hE0;
    localparam logic [7:0] TYPE_BITS = 8'h1F;
    localparam logic [7:0] FU_START  = 8'h80;
    localparam logic [7:0] FU_END    = 8'h40;

    typedef struct packed {
        logic [7:0] data;
        logic       pkt_end;
        logic       run_last;
    } stream_byte_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;     // data_byte[7:0], frame_size[31:8], timestamp[63:32]
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;     // out_byte[7:0]
    logic        m_tlast;
    logic        m_tuser;     // run_last
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [31:0] cfg_data;

    // register copies, at their reset values
    logic [15:0] limit_reg  = 16'd1262;
    logic        prefix_reg = 1'b1;
    logic [7:0]  chan_reg   = 8'd1;
    logic [7:0]  pt_reg     = 8'd96;
    logic [31:0] ssrc_reg   = 32'd0;

    // packetizer state
    logic [15:0] seq_num    = 16'd0;
    logic [23:0] nal_pos    = 24'd0;
    logic [15:0] bytes_left = 16'd0;
    logic [7:0]  nal_hdr    = 8'd0;
    logic        in_fu      = 1'b0;

    stream_byte_t pending_stream_bytes[$];

    int fail_count    = 0;
    int items_sent    = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int stall_request = 0;

    rtp_h264_nal_packetizer_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    initial
    begin
        #1_000_000;
        $display("rtp_h264_nal_packetizer_top_tb: FAIL");
        $finish;
    end

    task automatic report_mismatch(input string what);
        fail_count++;
        $display("mismatch at %0t: %s", $time, what);
    endtask

    // works out the stream bytes caused by one accepted nal byte
    task automatic packetize_byte(input logic [7:0] b, input logic [23:0] size_in,
                                  input logic [31:0] ts);
        logic [23:0]  sz;
        logic [23:0]  pos;
        logic [23:0]  remaining;
        logic [24:0]  pos_next;
        logic [15:0]  lim;
        logic [15:0]  n;
        logic [15:0]  len;
        logic [31:0]  prefix;
        logic [95:0]  rtp_hdr;
        logic [7:0]   fu_hdr;
        logic         first;
        logic         last;
        logic         ended;
        logic [7:0]   burst[$];
        stream_byte_t beat;

        sz  = (size_in == 24'd0) ? 24'd1 : size_in;
        lim = (limit_reg == 16'd0) ? 16'd1 : limit_reg;
        pos = nal_pos;

        if (pos == 24'd0)
        begin
            nal_hdr    = b;
            bytes_left = 16'd0;
            in_fu      = (sz > lim);
            // header of a fragmented nal is swallowed
            if (in_fu)
            begin
                nal_pos = 24'd1;
                return;
            end
        end

        if (bytes_left == 16'd0)
        begin
            remaining = (sz > pos) ? sz - pos : 24'd1;
            n         = (remaining < lim) ? remaining[15:0] : lim;
            first     = (pos == 24'd1);
            last      = (remaining <= lim);
            seq_num   = seq_num + 16'd1;
            len       = n + 16'd12 + (in_fu ? 16'd2 : 16'd0);
            prefix    = {DOLLAR, chan_reg, len};
            rtp_hdr   = {RTP_V2, pt_reg, seq_num, ts, ssrc_reg};
            if (prefix_reg)
                for (int i = 3; i >= 0; i--)
                    burst = {burst, prefix[i*8 +: 8]};
            for (int i = 11; i >= 0; i--)
                burst = {burst, rtp_hdr[i*8 +: 8]};
            if (in_fu)
            begin
                fu_hdr = (nal_hdr & TYPE_BITS) | (first ? FU_START : (last ? FU_END : 8'h00));
                burst = {burst, (nal_hdr & NRI_BITS) | FU_A};
                burst = {burst, fu_hdr};
            end
            bytes_left = n;
        end

        burst = {burst, b};
        bytes_left = bytes_left - 16'd1;
        pos_next   = {1'b0, pos} + 25'd1;
        ended      = (pos_next >= {1'b0, sz});
        if (ended)
        begin
            nal_pos    = 24'd0;
            in_fu      = 1'b0;
            bytes_left = 16'd0;
        end
        else
            nal_pos = pos_next[23:0];

        for (int i = 0; i < burst.size(); i++)
        begin
            beat.data     = burst[i];
            beat.run_last = (i == burst.size() - 1);
            beat.pkt_end  = beat.run_last && (ended || bytes_left == 16'd0);
            pending_stream_bytes = {pending_stream_bytes, beat};
        end
    endtask

    // one nal byte transaction; valid stays high for a following byte
    task automatic send_nal_byte(input logic [7:0] b, input logic [23:0] sz,
                                 input logic [31:0] ts);
        logic took;

        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {ts, sz, b};
        do
        begin
            @(negedge clk);
            took = s_tready;
            @(posedge clk);
        end
        while (!took);
        packetize_byte(b, sz, ts);
        items_sent++;
    endtask

    // header byte first, the rest random, all with the same size
    task automatic send_nal(input logic [23:0] sz, input logic [31:0] ts,
                            input logic [7:0] hdr, input int count);
        for (int k = 0; k < count; k++)
            send_nal_byte((k == 0) ? hdr : 8'($urandom_range(255)), sz, ts);
    endtask

    task automatic wait_results_done(input int settle);
        s_tvalid <= 1'b0;
        while (pending_stream_bytes.size() != 0)
            @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    // writes all five registers in turn, block must be idle
    task automatic apply_settings(input logic [15:0] lim, input logic pre,
                                  input logic [7:0] chan, input logic [7:0] pt,
                                  input logic [31:0] ssrc);
        logic [2:0]  reg_order[5] = '{rnp_pkg::CFG_PAYLOAD_LIMIT, rnp_pkg::CFG_PREFIX_ON,
                                      rnp_pkg::CFG_CHANNEL_ID, rnp_pkg::CFG_PAYLOAD_TYPE,
                                      rnp_pkg::CFG_SSRC};
        logic [31:0] reg_value[5];
        logic        took;

        reg_value = '{32'(lim), 32'(pre), 32'(chan), 32'(pt), ssrc};
        for (int i = 0; i < 5; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= reg_order[i];
            cfg_data  <= reg_value[i];
            do
            begin
                @(negedge clk);
                took = cfg_ready;
                @(posedge clk);
            end
            while (!took);
            case (reg_order[i])
                rnp_pkg::CFG_PAYLOAD_LIMIT: limit_reg  = reg_value[i][15:0];
                rnp_pkg::CFG_PREFIX_ON:     prefix_reg = reg_value[i][0];
                rnp_pkg::CFG_CHANNEL_ID:    chan_reg   = reg_value[i][7:0];
                rnp_pkg::CFG_PAYLOAD_TYPE:  pt_reg     = reg_value[i][7:0];
                rnp_pkg::CFG_SSRC:          ssrc_reg   = reg_value[i];
                default: ;
            endcase
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic test_reset_settings();
        send_nal_byte(8'hFF, 24'd2, 32'hFFFF_FFFF);
        send_nal_byte(8'h00, 24'd2, 32'hFFFF_FFFF);
        // zero size counts as a one-byte nal
        send_nal_byte(8'h65, 24'd0, 32'h0000_0000);
        wait_results_done(40);
    endtask

    task automatic test_fragments();
        apply_settings(16'd3, 1'b1, 8'hFF, 8'hFF, 32'hFFFF_FFFF);
        send_nal(24'd8, 32'h8000_0001, 8'hE5, 8);
        // one byte over the limit: the only fragment carries just the start bit
        send_nal(24'd4, 32'h0123_4567, 8'h1A, 4);
        wait_results_done(40);
    endtask

    task automatic test_limit_extremes();
        // zero limit acts as one
        apply_settings(16'd0, 1'b0, 8'h00, 8'h00, 32'h0);
        send_nal(24'd3, 32'h5A5A_A5A5, 8'h41, 3);
        wait_results_done(40);

        // prefix length wraps; the shrunken size ends the nal early
        apply_settings(16'hFFFF, 1'b1, 8'h01, 8'd96, 32'hDEAD_BEEF);
        send_nal_byte(8'h67, 24'd65530, 32'hA5A5_5A5A);
        send_nal_byte(8'h42, 24'd2, 32'hA5A5_5A5A);
        wait_results_done(40);

        apply_settings(16'd65521, 1'b1, 8'h80, 8'hE0, 32'h0F0F_F0F0);
        send_nal_byte(8'h65, 24'hFF_FFFF, 32'h1357_9BDF);
        send_nal_byte(8'h81, 24'hFF_FFFF, 32'h1357_9BDF);
        send_nal_byte(8'h7E, 24'd3, 32'h2468_ACE0);
        wait_results_done(40);
    endtask

    task automatic test_growing_nal();
        apply_settings(16'd2, 1'b1, 8'd9, 8'hE0, 32'h0000_0001);
        // size grows after the single packet is full: plain follow-on packets
        send_nal_byte(8'h61, 24'd2, 32'h0000_0010);
        send_nal_byte(8'h11, 24'd5, 32'h0000_0020);
        send_nal_byte(8'h22, 24'd5, 32'h0000_0030);
        send_nal_byte(8'h33, 24'd5, 32'h0000_0040);
        send_nal_byte(8'h44, 24'd5, 32'h0000_0050);
        wait_results_done(40);
    endtask

    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        apply_settings(16'd4, 1'b1, 8'd7, 8'hE0, 32'h1234_5678);
        stall_request = 400;
        for (int k = 0; k < 3; k++)
            send_nal(24'd9, $urandom(), 8'($urandom_range(255)), 9);
        // hold the input partway through a fragmented nal until the output catches up
        send_nal_byte(8'h5C, 24'd10, 32'hCAFE_0001);
        send_nal_byte(8'h01, 24'd10, 32'hCAFE_0001);
        send_nal_byte(8'h02, 24'd10, 32'hCAFE_0001);
        wait_results_done(1);
        for (int k = 3; k < 10; k++)
            send_nal_byte(8'($urandom_range(255)), 24'd10, 32'hCAFE_0002);
        wait_results_done(40);
    endtask

    task automatic test_random_traffic(input int send_pct, input int recv_pct,
                                       input int item_goal);
        logic [15:0] lim;
        logic [23:0] sz;
        logic [31:0] ts;
        int          goal;
        int          k;

        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        for (int part = 0; part < 2; part++)
        begin
            case ($urandom_range(3))
                0:       lim = 16'($urandom_range(1, 4));
                1:       lim = 16'($urandom_range(5, 16));
                2:       lim = 16'($urandom_range(17, 64));
                default: lim = 16'($urandom_range(0, 65535));
            endcase
            apply_settings(lim, 1'($urandom_range(1)), 8'($urandom_range(255)),
                           8'($urandom_range(255)), $urandom());
            goal = items_sent + item_goal / 2;
            while (items_sent < goal)
            begin
                ts = $urandom();
                if ($urandom_range(9) != 0)
                begin
                    sz = 24'($urandom_range(1, 16));
                    send_nal(sz, ts, 8'($urandom_range(255)), int'(sz));
                end
                else
                begin
                    // size read anew on every byte: the nal may end early or grow
                    k = 0;
                    do
                    begin
                        send_nal_byte(8'($urandom_range(255)), 24'($urandom_range(0, 12)),
                                      $urandom_range(1) ? ts : $urandom());
                        k++;
                    end
                    while (nal_pos != 24'd0 && k < 40);
                end
            end
            wait_results_done(40);
        end
    endtask

    // output side: random or long stalls, driven at the rising edge
    initial
    begin : output_ready
        int stall_left;

        stall_left = 0;
        m_tready   = 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall_request > 0)
            begin
                stall_left    = stall_request;
                stall_request = 0;
            end
            if (stall_left > 0)
            begin
                m_tready <= 1'b0;
                stall_left--;
            end
            else
                m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // each output transaction against the oldest expected byte
    always @(negedge clk)
    begin : check_output
        stream_byte_t want;

        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_stream_bytes.size() == 0)
                report_mismatch($sformatf("unexpected output byte %02h", m_tdata));
            else
            begin
                want = pending_stream_bytes.pop_front();
                if (m_tdata !== want.data)
                    report_mismatch($sformatf("out_byte %02h, want %02h", m_tdata, want.data));
                if (m_tlast !== want.pkt_end)
                    report_mismatch($sformatf("packet_end %b, want %b", m_tlast, want.pkt_end));
                if (m_tuser !== want.run_last)
                    report_mismatch($sformatf("run_last %b, want %b", m_tuser, want.run_last));
            end
        end
    end

    initial
    begin
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = 64'd0;
        cfg_valid = 1'b0;
        cfg_index = rnp_pkg::CFG_PAYLOAD_LIMIT;
        cfg_data  = 32'd0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        test_reset_settings();
        test_fragments();
        test_limit_extremes();
        test_growing_nal();
        test_backpressure();
        test_random_traffic(10, 69, 20);
        test_random_traffic(69, 10, 20);
        test_random_traffic(0, 0, 20);

        wait_results_done(40);
        if (fail_count == 0)
            $display("rtp_h264_nal_packetizer_top_tb: PASS");
        else
            $display("rtp_h264_nal_packetizer_top_tb: FAIL");
        $finish;
    end

endmodule

[filelist.f]
rtl/core/rnp_pkg.sv
rtl/core/rnp_front.sv
rtl/core/rnp_fifo.sv
rtl/core/rnp_back.sv
rtl/core/rtp_h264_nal_packetizer_top.sv
verif/rtp_h264_nal_packetizer_top_tb.sv
